// File: rtl/ising_pkg.sv
// Shared types and constants for the Ising Metropolis spin update block.
package ising_pkg;

  // Field widths of the stream payloads
  localparam int SITE_W = 12;
  localparam int RND_W  = 16;
  localparam int THR_W  = 16;
  localparam int EN_W   = 4;
  localparam int MAG_W  = 3;

  // Request kinds carried on in_tuser
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_THR_TWO  = 1'b0;
  localparam logic CFG_THR_FOUR = 1'b1;

  // Read sequence steps: the site itself, then its four neighbors
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_SELF  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_RIGHT = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LEFT  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DOWN  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_UP    = 3'd4;
  localparam logic [STEP_W-1:0] STEP_LAST  = 3'd5;

  // Magnetization steps on a flip
  localparam logic signed [MAG_W-1:0] MAG_POS = 3'sd2;
  localparam logic signed [MAG_W-1:0] MAG_NEG = -3'sd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DECIDE
  } state_t;

endpackage

// File: rtl/ising_spin_ram.sv
// One-bit spin lattice memory: one write port, one registered read port.
module ising_spin_ram #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];
  logic rdata_r;

  // Write one spin
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/ising_metropolis_spin_update.sv
// Top level: Metropolis single-spin update on a helical periodic 2D Ising lattice.
//
// Input stream (in_*): in_tuser is the request kind (load or update attempt),
// in_tdata carries site, spin to load and a 16-bit uniform random value.
// Result stream (out_*): one transaction per input transaction, carrying the
// flip flag, the spin afterwards, the energy step and the magnetization step.
// Config port (cfg_*): writes the two acceptance thresholds, write only.
//
// Sequence per item: a load is accepted, then written with its result, and an
// out-of-range site is accepted, then answered without a write; an update
// attempt is accepted, then runs the read sequence, in which one shared address
// adder with wrap-around compare steps through the site and its four neighbors
// on the single read port of the spin memory, then the decision, write-back and
// result. in_tready is high only while no item is in flight. A result appears
// in out_tdata in the cycle after the decision and holds until taken; the next
// item is accepted while it waits, and its decision stalls until the output register is free.
// Reset clears the control state and the thresholds; spin memory contents
// are undefined until loaded.
module ising_metropolis_spin_update
  import ising_pkg::*;
#(
  parameter int LATTICE_SIDE = 64,
  parameter int SITE_COUNT   = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // site_index[11:0], load_spin[12], random_value[28:13]
  input  logic        in_tuser,   // req_type[0]
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // flipped[0], spin_after[1], energy_step[5:2], magnet_step[8:6]
  // Configuration port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int AW = $clog2(SITE_COUNT);
  localparam int SW = (AW > SITE_W) ? AW : SITE_W;
  localparam int SIDE_MOD = LATTICE_SIDE % SITE_COUNT;
  localparam logic [SW:0] SITE_LIMIT = (SW+1)'(SITE_COUNT);
  localparam logic [AW:0] N_A        = (AW+1)'(SITE_COUNT);
  localparam logic [AW:0] OFF_SELF   = '0;
  localparam logic [AW:0] OFF_RIGHT  = (AW+1)'(1);
  localparam logic [AW:0] OFF_LEFT   = (AW+1)'(SITE_COUNT - 1);
  localparam logic [AW:0] OFF_DOWN   = (AW+1)'(SIDE_MOD);
  localparam logic [AW:0] OFF_UP     = (AW+1)'(SITE_COUNT - SIDE_MOD);

  // Control registers
  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [THR_W-1:0]    thr_two_r, thr_four_r;

  // Item and result payload registers
  logic                req_r, req_nxt;
  logic [AW-1:0]       site_r, site_nxt;
  logic                ld_r, ld_nxt;
  logic [RND_W-1:0]    rnd_r, rnd_nxt;
  logic                in_range_r, in_range_nxt;
  logic                spin_r, spin_nxt;
  logic [2:0]          ncnt_r, ncnt_nxt;
  logic                flipped_r, flipped_nxt;
  logic                spin_after_r, spin_after_nxt;
  logic signed [EN_W-1:0]  energy_r, energy_nxt;
  logic signed [MAG_W-1:0] magnet_r, magnet_nxt;

  // Datapath signals
  logic [SW:0]         ext_site;
  logic                in_range;
  logic [AW:0]         off_sel;
  logic [AW:0]         addr_sum;
  logic [AW:0]         addr_wrap;
  logic [AW-1:0]       rd_addr;
  logic                rd_data;
  logic                ram_we;
  logic                ram_wdata;
  logic                out_free;
  logic signed [3:0]   half_delta;
  logic                flip;

  // Range check on the incoming site
  assign ext_site = (SW+1)'(in_tdata[SITE_W-1:0]);
  assign in_range = ext_site < SITE_LIMIT;

  // Select the neighbor offset for this read step
  always_comb begin
    unique case (cnt_r)
      STEP_SELF:  off_sel = OFF_SELF;
      STEP_RIGHT: off_sel = OFF_RIGHT;
      STEP_LEFT:  off_sel = OFF_LEFT;
      STEP_DOWN:  off_sel = OFF_DOWN;
      STEP_UP:    off_sel = OFF_UP;
      default:    off_sel = OFF_SELF;
    endcase
  end

  // Shared address unit: add offset, wrap modulo the site count
  assign addr_sum  = {1'b0, site_r} + off_sel;
  assign addr_wrap = (addr_sum >= N_A) ? (addr_sum - N_A) : addr_sum;
  assign rd_addr   = addr_wrap[AW-1:0];

  ising_spin_ram #(
    .DEPTH (SITE_COUNT)
  ) u_spin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (site_r),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Half of delta: neighbor sum over two, times the site spin
  assign half_delta = spin_r ? ($signed({1'b0, ncnt_r}) - 4'sd2)
                             : (4'sd2 - $signed({1'b0, ncnt_r}));

  // Metropolis acceptance
  always_comb begin
    priority if (half_delta <= 4'sd0) begin
      flip = 1'b1;
    end else if (half_delta == 4'sd1) begin
      flip = rnd_r < thr_two_r;
    end else if (half_delta == 4'sd2) begin
      flip = rnd_r < thr_four_r;
    end else begin
      flip = 1'b0;
    end
  end

  assign out_free = !out_valid_r || out_tready;

  // Sequencer: next state, payload and memory write
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    req_nxt        = req_r;
    site_nxt       = site_r;
    ld_nxt         = ld_r;
    rnd_nxt        = rnd_r;
    in_range_nxt   = in_range_r;
    spin_nxt       = spin_r;
    ncnt_nxt       = ncnt_r;
    flipped_nxt    = flipped_r;
    spin_after_nxt = spin_after_r;
    energy_nxt     = energy_r;
    magnet_nxt     = magnet_r;
    ram_we         = 1'b0;
    ram_wdata      = 1'b0;
    in_tready      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready    = 1'b1;
        req_nxt      = in_tuser;
        site_nxt     = ext_site[AW-1:0];
        ld_nxt       = in_tdata[SITE_W];
        rnd_nxt      = in_tdata[SITE_W+RND_W:SITE_W+1];
        in_range_nxt = in_range;
        cnt_nxt      = STEP_SELF;
        ncnt_nxt     = '0;
        if (in_tvalid) begin
          if (in_range && (in_tuser == REQ_UPDATE)) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_READ: begin
        cnt_nxt = cnt_r + 3'd1;
        // Collect the read issued in the previous step
        if (cnt_r == STEP_RIGHT) begin
          spin_nxt = rd_data;
        end else if (cnt_r != STEP_SELF) begin
          ncnt_nxt = ncnt_r + {2'b00, rd_data};
        end
        if (cnt_r == STEP_LAST) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (!in_range_r) begin
            flipped_nxt    = 1'b0;
            spin_after_nxt = 1'b0;
            energy_nxt     = '0;
            magnet_nxt     = '0;
          end else if (req_r == REQ_LOAD) begin
            ram_we         = 1'b1;
            ram_wdata      = ld_r;
            flipped_nxt    = 1'b0;
            spin_after_nxt = ld_r;
            energy_nxt     = '0;
            magnet_nxt     = '0;
          end else if (flip) begin
            ram_we         = 1'b1;
            ram_wdata      = !spin_r;
            flipped_nxt    = 1'b1;
            spin_after_nxt = !spin_r;
            energy_nxt     = {half_delta[2:0], 1'b0};
            magnet_nxt     = spin_r ? MAG_NEG : MAG_POS;
          end else begin
            flipped_nxt    = 1'b0;
            spin_after_nxt = spin_r;
            energy_nxt     = '0;
            magnet_nxt     = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= STEP_SELF;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_two_r  <= '0;
      thr_four_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THR_TWO:  thr_two_r  <= cfg_wdata;
        CFG_THR_FOUR: thr_four_r <= cfg_wdata;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    site_r       <= site_nxt;
    ld_r         <= ld_nxt;
    rnd_r        <= rnd_nxt;
    in_range_r   <= in_range_nxt;
    spin_r       <= spin_nxt;
    ncnt_r       <= ncnt_nxt;
    flipped_r    <= flipped_nxt;
    spin_after_r <= spin_after_nxt;
    energy_r     <= energy_nxt;
    magnet_r     <= magnet_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, magnet_r, energy_r, spin_after_r, flipped_r};

  // An in-range update always starts the read sequence at the site itself
  a_update_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_range && (in_tuser == REQ_UPDATE))
      |=> (state_r == ST_READ) && (cnt_r == STEP_SELF))
    else $error("update did not start the read sequence");

  // A new result comes only out of the decision step
  a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DECIDE))
    else $error("result raised outside the decision step");

  // Magnetization and energy steps match the flip and the new spin
  a_magnet_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (flipped_r ? (magnet_r == (spin_after_r ? MAG_POS : MAG_NEG))
                               : ((magnet_r == '0) && (energy_r == '0))))
    else $error("magnetization or energy step inconsistent with flip");

  // A memory write ends the item
  a_write_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (state_r == ST_IDLE) && out_valid_r)
    else $error("spin write did not complete the item");

endmodule

// File: tb/ising_metropolis_spin_update_tb.sv
// Self-checking testbench for the Ising Metropolis spin update block.
`timescale 1ns / 1ps

module ising_metropolis_spin_update_tb
  import ising_pkg::*;
();

  localparam int LATTICE_SIDE = 64;
  localparam int SITE_COUNT   = 4096;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 340;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic              req;
    logic [SITE_W-1:0] site;
    logic              ld;
    logic [RND_W-1:0]  rnd;
  } spin_req_t;

  typedef struct packed {
    logic                    flipped;
    logic                    spin_after;
    logic signed [EN_W-1:0]  energy_step;
    logic signed [MAG_W-1:0] magnet_step;
  } spin_res_t;

  typedef struct {
    spin_req_t item;
    bit        typed;
    spin_res_t res;
  } dir_row_t;

  localparam spin_res_t SPIN_DOWN_RES = '0;
  localparam spin_res_t SPIN_UP_RES   = '{1'b0, 1'b1, 4'sd0, 3'sd0};
  localparam spin_res_t FULL_DROP_RES = '{1'b1, 1'b0, -4'sd4, MAG_NEG};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // site_index[11:0], load_spin[12], random_value[28:13]
  logic        in_tuser;   // req_type[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // flipped[0], spin_after[1], energy_step[5:2], magnet_step[8:6]
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  // Lattice mirror, thresholds and bookkeeping of written sites
  bit               lattice_spin [SITE_COUNT];
  bit               site_loaded  [SITE_COUNT];
  bit               ready_mark   [SITE_COUNT];
  int               loaded_sites [$];
  int               ready_sites  [$];
  int               last_update_site;
  logic [THR_W-1:0] thr_two;
  logic [THR_W-1:0] thr_four;
  int               hop [5] = '{0, 1, -1, LATTICE_SIDE, -LATTICE_SIDE};

  spin_res_t expected_spins [$];
  int        mismatch_count;
  int        send_burst;
  int        recv_burst;
  bit        hold_off_req;

  // Site 0 sits at a corner: its neighbors wrap to the bottom row and to the far end
  dir_row_t dir_tab [21] = '{
    '{'{REQ_LOAD,   12'd0,    1'b1, 16'h0000}, 1'b1, SPIN_UP_RES},
    '{'{REQ_LOAD,   12'd1,    1'b1, 16'hFFFF}, 1'b1, SPIN_UP_RES},
    '{'{REQ_LOAD,   12'd4095, 1'b1, 16'h0000}, 1'b1, SPIN_UP_RES},
    '{'{REQ_LOAD,   12'd64,   1'b1, 16'h5A5A}, 1'b1, SPIN_UP_RES},
    '{'{REQ_LOAD,   12'd4032, 1'b1, 16'hA5A5}, 1'b1, SPIN_UP_RES},
    '{'{REQ_UPDATE, 12'd0,    1'b0, 16'h0000}, 1'b1, SPIN_UP_RES},
    '{'{REQ_UPDATE, 12'd0,    1'b1, 16'hFFFF}, 1'b1, SPIN_UP_RES},
    '{'{REQ_LOAD,   12'd4095, 1'b0, 16'h1234}, 1'b1, SPIN_DOWN_RES},
    '{'{REQ_UPDATE, 12'd0,    1'b0, 16'h0000}, 1'b1, SPIN_UP_RES},
    '{'{REQ_LOAD,   12'd1,    1'b0, 16'h8001}, 1'b1, SPIN_DOWN_RES},
    '{'{REQ_LOAD,   12'd64,   1'b0, 16'h7FFE}, 1'b1, SPIN_DOWN_RES},
    '{'{REQ_UPDATE, 12'd0,    1'b0, 16'hFFFF}, 1'b0, SPIN_DOWN_RES},
    '{'{REQ_UPDATE, 12'd0,    1'b1, 16'h0000}, 1'b0, SPIN_DOWN_RES},
    '{'{REQ_LOAD,   12'd4032, 1'b0, 16'h00FF}, 1'b1, SPIN_DOWN_RES},
    '{'{REQ_UPDATE, 12'd0,    1'b0, 16'h0000}, 1'b0, SPIN_DOWN_RES},
    '{'{REQ_LOAD,   12'd0,    1'b1, 16'hFF00}, 1'b1, SPIN_UP_RES},
    '{'{REQ_UPDATE, 12'd0,    1'b0, 16'h0000}, 1'b1, FULL_DROP_RES},
    '{'{REQ_LOAD,   12'd4094, 1'b1, 16'h0F0F}, 1'b1, SPIN_UP_RES},
    '{'{REQ_LOAD,   12'd63,   1'b1, 16'hF0F0}, 1'b1, SPIN_UP_RES},
    '{'{REQ_LOAD,   12'd4031, 1'b0, 16'h3C3C}, 1'b1, SPIN_DOWN_RES},
    '{'{REQ_UPDATE, 12'd4095, 1'b1, 16'hFFFF}, 1'b0, SPIN_DOWN_RES}
  };

  ising_metropolis_spin_update #(
    .LATTICE_SIDE(LATTICE_SIDE),
    .SITE_COUNT  (SITE_COUNT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int wrap_site(int site, int offset);
    return (site + offset + SITE_COUNT) % SITE_COUNT;
  endfunction

  function automatic int spin_pm(int site);
    return lattice_spin[site] ? 1 : -1;
  endfunction

  // Record a loaded site and promote any site whose whole neighborhood is now known
  function automatic void mark_loaded(int site);
    int  c;
    bit  all_known;
    if (!site_loaded[site]) begin
      site_loaded[site] = 1'b1;
      loaded_sites.push_back(site);
    end
    for (int k = 0; k < 5; k++) begin
      c = wrap_site(site, hop[k]);
      all_known = 1'b1;
      for (int j = 0; j < 5; j++) begin
        if (!site_loaded[wrap_site(c, hop[j])]) all_known = 1'b0;
      end
      if (all_known && !ready_mark[c]) begin
        ready_mark[c] = 1'b1;
        ready_sites.push_back(c);
      end
    end
  endfunction

  // Apply one transaction to the lattice mirror and return its result
  function automatic spin_res_t metropolis_step(spin_req_t r);
    spin_res_t res;
    int        site;
    int        nsum;
    int        s;
    int        delta;
    bit        take;
    res  = '0;
    site = int'(r.site);
    if (r.req == REQ_LOAD) begin
      lattice_spin[site] = r.ld;
      mark_loaded(site);
      res.spin_after = r.ld;
      return res;
    end
    nsum = spin_pm(wrap_site(site, 1)) + spin_pm(wrap_site(site, -1))
         + spin_pm(wrap_site(site, LATTICE_SIDE)) + spin_pm(wrap_site(site, -LATTICE_SIDE));
    s     = spin_pm(site);
    delta = nsum * s;
    take  = (delta <= 0) || (delta == 2 && r.rnd < thr_two) || (delta == 4 && r.rnd < thr_four);
    if (take) begin
      lattice_spin[site] = (s < 0);
      res.flipped     = 1'b1;
      res.spin_after  = (s < 0);
      res.energy_step = EN_W'(delta);
      res.magnet_step = (s < 0) ? MAG_POS : MAG_NEG;
    end else begin
      res.spin_after = (s > 0);
    end
    return res;
  endfunction

  // Idle length for one transaction, with occasional back-to-back stretches
  function automatic int draw_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  // Mostly clustered loads and updates on fully known neighborhoods
  function automatic spin_req_t next_random_item();
    spin_req_t        r;
    int               cand;
    logic [THR_W-1:0] base;
    r.rnd = RND_W'($urandom);
    r.ld  = 1'($urandom_range(0, 1));
    if (ready_sites.size() > 0 && $urandom_range(0, 9) < 6) begin
      r.req = REQ_UPDATE;
      // revisit the last site or a neighbor of it now and then
      cand = wrap_site(last_update_site, hop[$urandom_range(0, 4)]);
      if ($urandom_range(0, 2) != 0 || !ready_mark[cand])
        cand = ready_sites[$urandom_range(0, ready_sites.size() - 1)];
      last_update_site = cand;
      r.site = SITE_W'(cand);
      // land on the acceptance boundary now and then
      if ($urandom_range(0, 3) == 0) begin
        base  = $urandom_range(0, 1) ? thr_two : thr_four;
        r.rnd = base + RND_W'($urandom_range(0, 2)) - 16'd1;
      end
    end else begin
      r.req = REQ_LOAD;
      if (loaded_sites.size() > 0 && $urandom_range(0, 9) < 7)
        cand = wrap_site(loaded_sites[$urandom_range(0, loaded_sites.size() - 1)],
                         hop[$urandom_range(1, 4)]);
      else
        cand = $urandom_range(0, SITE_COUNT - 1);
      r.site = SITE_W'(cand);
    end
    return r;
  endfunction

  // Offer one transaction and queue its expected result once accepted
  task automatic send_item(input spin_req_t r, input bit typed, input spin_res_t typed_res);
    int        gap;
    spin_res_t want;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= r.req;
    in_tdata  <= {3'b000, r.rnd, r.ld, r.site};
    do @(posedge clk); while (!in_tready);
    want = metropolis_step(r);
    expected_spins.push_back(typed ? typed_res : want);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_spins.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic idx, input logic [THR_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_THR_TWO) thr_two = val;
    else thr_four = val;
  endtask

  function automatic void compare_field(string label, logic signed [7:0] want,
                                        logic signed [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_result(input logic [15:0] data);
    spin_res_t got;
    spin_res_t want;
    got.flipped     = data[0];
    got.spin_after  = data[1];
    got.energy_step = data[5:2];
    got.magnet_step = data[8:6];
    if (expected_spins.size() == 0) begin
      $display("%0t ns: result with nothing pending, expected none, actual %h", $time, data);
      mismatch_count++;
    end else begin
      want = expected_spins.pop_front();
      compare_field("flipped", 8'(want.flipped), 8'(got.flipped));
      compare_field("spin_after", 8'(want.spin_after), 8'(got.spin_after));
      compare_field("energy_step", 8'(want.energy_step), 8'(got.energy_step));
      compare_field("magnet_step", 8'(want.magnet_step), 8'(got.magnet_step));
    end
  endtask

  // Result side: random back-pressure, one long hold on request
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(recv_burst);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      check_result(out_tdata);
    end
  end

  // Main sequence: reset, directed rows, then random phases over threshold settings
  initial begin
    logic [THR_W-1:0] plan_two  [PHASES];
    logic [THR_W-1:0] plan_four [PHASES];
    rst_n            = 1'b0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    in_tuser         = REQ_LOAD;
    cfg_we           = 1'b0;
    cfg_index        = CFG_THR_TWO;
    cfg_wdata        = '0;
    thr_two          = '0;
    thr_four         = '0;
    mismatch_count   = 0;
    send_burst       = 0;
    recv_burst       = 0;
    hold_off_req     = 1'b0;
    last_update_site = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);
    drain_results();

    plan_two  = '{16'hFFFF, 16'($urandom), 16'h0000, 16'hFFFF, 16'($urandom)};
    plan_four = '{16'hFFFF, 16'($urandom), 16'hFFFF, 16'h0000, 16'($urandom)};
    for (int ph = 0; ph < PHASES; ph++) begin
      write_threshold(CFG_THR_TWO, plan_two[ph]);
      write_threshold(CFG_THR_FOUR, plan_four[ph]);
      if (ph == 1) hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) send_item(next_random_item(), 1'b0, SPIN_DOWN_RES);
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_spins.size() == 0) begin
      $display("[ising_metropolis_spin_update] OK");
    end else begin
      $display("[ising_metropolis_spin_update] ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2_000_000;
    $display("[ising_metropolis_spin_update] ERROR");
    $finish;
  end

endmodule
